[sv/srp_pkg.sv]
// Shared types, constants and codes for the skyline rectangle packer.
`default_nettype none
package srp_pkg;

  // Skyline store size and coordinate width.
  localparam int MAX_SEGMENTS = 64;
  localparam int COORD_BITS   = 14;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int PUSH_W       = CNT_W + 1;
  localparam int WORK_SLOTS   = MAX_SEGMENTS + 2;

  // Derived arithmetic widths.
  localparam int PAD_W = 8;
  localparam int DIM_W = COORD_BITS + 1;
  localparam int SUM_W = COORD_BITS + 2;
  localparam int CUR_W = COORD_BITS + CNT_W + 1;
  localparam int ID_W  = 16;

  // Configuration port.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_ATLAS_WIDTH  = 2'd0;
  localparam logic [1:0] REG_ATLAS_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PADDING      = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_PLACED = 2'd0;
  localparam logic [1:0] ST_NO_FIT = 2'd1;
  localparam logic [1:0] ST_SKIP   = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // One skyline segment.
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] top;
    logic [COORD_BITS-1:0] span;
  } seg_t;

  // Configuration register values.
  typedef struct packed {
    logic [COORD_BITS-1:0] atlas_width;
    logic [COORD_BITS-1:0] atlas_height;
    logic [PAD_W-1:0]      padding;
  } cfg_t;

  // Control from the sequencer to the merge unit.
  typedef struct packed {
    logic clear;
    logic push;
    logic flush;
    seg_t seg;
  } merge_ctl_t;

  // Write request from the merge unit into the spare bank.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    seg_t             seg;
  } seg_wr_t;

endpackage
`default_nettype wire

[sv/srp_seg_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module srp_seg_ram #(
  parameter int DATA_W = 42,
  parameter int ADDR_W = 7
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

[sv/srp_cfg.sv]
// APB register file holding atlas size and padding.
`default_nettype none
module srp_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [srp_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [srp_pkg::PDATA_W-1:0]    pwdata,
  output logic      [srp_pkg::PDATA_W-1:0]    prdata,
  output logic                                pready,
  output srp_pkg::cfg_t                       cfg_o
);
  import srp_pkg::*;

  cfg_t       cfg_q;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Register writes in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.atlas_width  <= COORD_BITS'(1024);
      cfg_q.atlas_height <= COORD_BITS'(1024);
      cfg_q.padding      <= PAD_W'(1);
    end else if (wr_en) begin
      case (reg_idx)
        REG_ATLAS_WIDTH:  cfg_q.atlas_width  <= pwdata[COORD_BITS-1:0];
        REG_ATLAS_HEIGHT: cfg_q.atlas_height <= pwdata[COORD_BITS-1:0];
        REG_PADDING:      cfg_q.padding      <= pwdata[PAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (reg_idx)
      REG_ATLAS_WIDTH:  prdata = PDATA_W'(cfg_q.atlas_width);
      REG_ATLAS_HEIGHT: prdata = PDATA_W'(cfg_q.atlas_height);
      REG_PADDING:      prdata = PDATA_W'(cfg_q.padding);
      default:          prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[sv/srp_merge.sv]
// Streaming merge of the rebuilt skyline into the spare memory bank.
`default_nettype none
module srp_merge (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  srp_pkg::merge_ctl_t                ctl_i,
  output srp_pkg::seg_wr_t                   wr_o,
  output logic      [srp_pkg::PUSH_W-1:0]    raw_cnt_o,
  output logic      [srp_pkg::PUSH_W-1:0]    out_cnt_o
);
  import srp_pkg::*;

  seg_t              pend_q;
  logic              pend_v_q;
  logic [PUSH_W-1:0] raw_q;
  logic [PUSH_W-1:0] out_q;
  logic [COORD_BITS-1:0] pend_end;
  logic              match;
  logic              emit;

  // A new segment joins the pending one when heights agree and edges touch.
  assign pend_end = pend_q.x + pend_q.span;
  assign match = pend_v_q && (pend_q.top == ctl_i.seg.top) && (pend_end == ctl_i.seg.x);
  assign emit  = pend_v_q && ((ctl_i.push && !match) || ctl_i.flush);

  assign wr_o.we    = emit && (out_q < PUSH_W'(MAX_SEGMENTS));
  assign wr_o.idx   = out_q[IDX_W-1:0];
  assign wr_o.seg   = pend_q;
  assign raw_cnt_o  = raw_q;
  assign out_cnt_o  = out_q;

  // Control state of the merge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      raw_q    <= '0;
      out_q    <= '0;
    end else if (ctl_i.clear) begin
      pend_v_q <= 1'b0;
      raw_q    <= '0;
      out_q    <= '0;
    end else begin
      if (emit) begin
        out_q <= out_q + 1'b1;
      end
      if (ctl_i.push) begin
        raw_q    <= raw_q + 1'b1;
        pend_v_q <= 1'b1;
      end else if (ctl_i.flush) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  // Pending segment payload.
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      if (match) begin
        pend_q.span <= pend_q.span + ctl_i.seg.span;
      end else begin
        pend_q <= ctl_i.seg;
      end
    end
  end

endmodule
`default_nettype wire

[sv/skyline_rect_packer_top.sv]
// Top level of the skyline rectangle packer: sequencer, segment memory and merge.
// The block takes one rectangle at a time and raises done_o for one cycle with
// its result; the receiver cannot stall it. A rectangle skipped after a batch
// failure keeps busy_o high for one cycle, and its result follows in the next
// cycle. A placement holds busy_o through a scan of the skyline and then a
// rebuild of it, both reading through the single read port of the segment
// memory. A rectangle that does not fit ends after the scan. A first rectangle
// of a batch passes through an extra initialisation state first. The skyline
// lives in two banks of the memory, and a successful rebuild swaps them.
`default_nettype none
module skyline_rect_packer_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          first_of_batch_i,
  input  wire logic [srp_pkg::ID_W-1:0]      rect_id_i,
  input  wire logic [srp_pkg::COORD_BITS-1:0] rect_width_i,
  input  wire logic [srp_pkg::COORD_BITS-1:0] rect_height_i,
  output logic                               done_o,
  output logic      [srp_pkg::ID_W-1:0]      placed_id_o,
  output logic      [srp_pkg::COORD_BITS-1:0] place_x_o,
  output logic      [srp_pkg::COORD_BITS-1:0] place_y_o,
  output logic      [1:0]                    status_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [srp_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [srp_pkg::PDATA_W-1:0]   pwdata,
  output logic      [srp_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);
  import srp_pkg::*;

  // Sequencer states.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INIT    = 4'd1;
  localparam logic [3:0] S_CHECK   = 4'd2;
  localparam logic [3:0] S_ORD     = 4'd3;
  localparam logic [3:0] S_OCHK    = 4'd4;
  localparam logic [3:0] S_INNER   = 4'd5;
  localparam logic [3:0] S_SCANEND = 4'd6;
  localparam logic [3:0] S_R1RD    = 4'd7;
  localparam logic [3:0] S_R1      = 4'd8;
  localparam logic [3:0] S_NEW     = 4'd9;
  localparam logic [3:0] S_R2RD    = 4'd10;
  localparam logic [3:0] S_R2      = 4'd11;
  localparam logic [3:0] S_FLUSH   = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;

  cfg_t cfg;

  logic [3:0] state_q, state_d;
  logic       bank_q, bank_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic       failed_q, failed_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic       found_q, found_d;
  logic       done_q, done_d;
  logic [1:0] st_q, st_d;
  logic [COORD_BITS-1:0] px_q, px_d;
  logic [COORD_BITS-1:0] py_q, py_d;

  logic [ID_W-1:0]       id_q;
  logic [DIM_W-1:0]      rw_q, rh_q;
  logic [COORD_BITS-1:0] left_q, left_d;
  logic [COORD_BITS-1:0] maxtop_q, maxtop_d;
  logic [CUR_W-1:0]      cur_q, cur_d;
  logic [SUM_W-1:0]      lim_q, lim_d;
  logic [COORD_BITS-1:0] besth_q, besth_d;
  logic [COORD_BITS-1:0] besttop_q, besttop_d;
  logic [COORD_BITS-1:0] bestx_q, bestx_d;

  logic [IDX_W-1:0]  rd_idx;
  seg_t              rdata;
  merge_ctl_t        mctl;
  seg_wr_t           mwr;
  logic [PUSH_W-1:0] raw_cnt, out_cnt;
  logic              ram_we;
  logic [IDX_W:0]    ram_waddr;
  seg_t              ram_wdata;

  logic              accept;
  logic [SUM_W-1:0]  ochk_sum;
  logic              inner_go;
  logic [SUM_W-1:0]  cand;
  logic [DIM_W-1:0]  seg_end;
  logic [SUM_W-1:0]  right;

  srp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Write port: batch start seeds entry 0 of the live bank, else merge output.
  always_comb begin
    if (state_q == S_INIT) begin
      ram_we        = 1'b1;
      ram_waddr     = {bank_q, {IDX_W{1'b0}}};
      ram_wdata.x   = '0;
      ram_wdata.top = COORD_BITS'(cfg.padding);
      ram_wdata.span = cfg.atlas_width;
    end else begin
      ram_we    = mwr.we;
      ram_waddr = {~bank_q, mwr.idx};
      ram_wdata = mwr.seg;
    end
  end

  srp_seg_ram #(
    .DATA_W ($bits(seg_t)),
    .ADDR_W (IDX_W + 1)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i ({bank_q, rd_idx}),
    .rdata_o (rdata)
  );

  srp_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mctl),
    .wr_o      (mwr),
    .raw_cnt_o (raw_cnt),
    .out_cnt_o (out_cnt)
  );

  assign accept   = start_i && !busy_o;
  assign busy_o   = (state_q != S_IDLE);
  assign ochk_sum = SUM_W'(rdata.x) + SUM_W'(rw_q);
  assign inner_go = (j_q < cnt_q) && (cur_q < CUR_W'(lim_q));
  assign cand     = SUM_W'(maxtop_q) + SUM_W'(rh_q);
  assign seg_end  = DIM_W'(rdata.x) + DIM_W'(rdata.span);
  assign right    = SUM_W'(bestx_q) + SUM_W'(rw_q);

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    bank_d    = bank_q;
    cnt_d     = cnt_q;
    failed_d  = failed_q;
    i_d       = i_q;
    j_d       = j_q;
    found_d   = found_q;
    done_d    = 1'b0;
    st_d      = st_q;
    px_d      = px_q;
    py_d      = py_q;
    left_d    = left_q;
    maxtop_d  = maxtop_q;
    cur_d     = cur_q;
    lim_d     = lim_q;
    besth_d   = besth_q;
    besttop_d = besttop_q;
    bestx_d   = bestx_q;
    rd_idx    = i_q[IDX_W-1:0];
    mctl      = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = first_of_batch_i ? S_INIT : S_CHECK;
        end
      end
      S_INIT: begin
        cnt_d    = CNT_W'(1);
        failed_d = 1'b0;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        mctl.clear = 1'b1;
        i_d        = '0;
        found_d    = 1'b0;
        besth_d    = cfg.atlas_height;
        bestx_d    = '0;
        if (failed_q) begin
          done_d  = 1'b1;
          st_d    = ST_SKIP;
          px_d    = '0;
          py_d    = '0;
          state_d = S_IDLE;
        end else if (cnt_q == '0) begin
          state_d = S_SCANEND;
        end else begin
          state_d = S_ORD;
        end
      end
      S_ORD: begin
        state_d = S_OCHK;
      end
      S_OCHK: begin
        if (ochk_sum > SUM_W'(cfg.atlas_width)) begin
          if (i_q + 1'b1 >= cnt_q) begin
            state_d = S_SCANEND;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_ORD;
          end
        end else begin
          left_d   = rdata.x;
          maxtop_d = rdata.top;
          cur_d    = CUR_W'(rdata.x);
          lim_d    = ochk_sum;
          j_d      = i_q;
          state_d  = S_INNER;
        end
      end
      S_INNER: begin
        rd_idx = j_q[IDX_W-1:0] + 1'b1;
        if (inner_go) begin
          if (rdata.top > maxtop_q) begin
            maxtop_d = rdata.top;
          end
          cur_d = cur_q + CUR_W'(rdata.span);
          j_d   = j_q + 1'b1;
        end else begin
          if (cand < SUM_W'(besth_q)) begin
            besth_d   = cand[COORD_BITS-1:0];
            besttop_d = maxtop_q;
            bestx_d   = left_q;
            found_d   = 1'b1;
          end
          if (i_q + 1'b1 >= cnt_q) begin
            state_d = S_SCANEND;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_ORD;
          end
        end
      end
      S_SCANEND: begin
        i_d = '0;
        if (!found_q) begin
          done_d   = 1'b1;
          st_d     = ST_NO_FIT;
          px_d     = '0;
          py_d     = '0;
          failed_d = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_R1RD;
        end
      end
      S_R1RD: begin
        state_d = (i_q >= cnt_q) ? S_NEW : S_R1;
      end
      S_R1: begin
        // Segments left of the new one, the last one clipped at its left edge.
        if (seg_end <= DIM_W'(bestx_q)) begin
          mctl.push = 1'b1;
          mctl.seg  = rdata;
          i_d       = i_q + 1'b1;
          state_d   = S_R1RD;
        end else if (rdata.x < bestx_q) begin
          mctl.push     = 1'b1;
          mctl.seg.x    = rdata.x;
          mctl.seg.top  = rdata.top;
          mctl.seg.span = bestx_q - rdata.x;
          i_d           = i_q + 1'b1;
          state_d       = S_R1RD;
        end else begin
          state_d = S_NEW;
        end
      end
      S_NEW: begin
        mctl.push     = 1'b1;
        mctl.seg.x    = bestx_q;
        mctl.seg.top  = besth_q;
        mctl.seg.span = rw_q[COORD_BITS-1:0];
        i_d           = '0;
        state_d       = S_R2RD;
      end
      S_R2RD: begin
        state_d = (i_q >= cnt_q) ? S_FLUSH : S_R2;
      end
      S_R2: begin
        // Segments right of the new one, the first one clipped at the right edge.
        if (SUM_W'(rdata.x) >= right) begin
          mctl.push = 1'b1;
          mctl.seg  = rdata;
        end else if (SUM_W'(seg_end) > right) begin
          mctl.push     = 1'b1;
          mctl.seg.x    = right[COORD_BITS-1:0];
          mctl.seg.top  = rdata.top;
          mctl.seg.span = COORD_BITS'(SUM_W'(seg_end) - right);
        end
        i_d     = i_q + 1'b1;
        state_d = S_R2RD;
      end
      S_FLUSH: begin
        mctl.flush = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if ((raw_cnt > PUSH_W'(WORK_SLOTS)) || (out_cnt > PUSH_W'(MAX_SEGMENTS))) begin
          st_d     = ST_FULL;
          px_d     = '0;
          py_d     = '0;
          failed_d = 1'b1;
        end else begin
          st_d   = ST_PLACED;
          px_d   = bestx_q + COORD_BITS'(cfg.padding);
          py_d   = besttop_q;
          bank_d = ~bank_q;
          cnt_d  = out_cnt[CNT_W-1:0];
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      bank_q   <= 1'b0;
      cnt_q    <= '0;
      failed_q <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
      found_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      bank_q   <= bank_d;
      cnt_q    <= cnt_d;
      failed_q <= failed_d;
      i_q      <= i_d;
      j_q      <= j_d;
      found_q  <= found_d;
      done_q   <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      id_q    <= rect_id_i;
      rw_q    <= DIM_W'(rect_width_i) + DIM_W'(cfg.padding);
      rh_q    <= DIM_W'(rect_height_i) + DIM_W'(cfg.padding);
    end
    st_q      <= st_d;
    px_q      <= px_d;
    py_q      <= py_d;
    left_q    <= left_d;
    maxtop_q  <= maxtop_d;
    cur_q     <= cur_d;
    lim_q     <= lim_d;
    besth_q   <= besth_d;
    besttop_q <= besttop_d;
    bestx_q   <= bestx_d;
  end

  assign done_o      = done_q;
  assign placed_id_o = id_q;
  assign place_x_o   = px_q;
  assign place_y_o   = py_q;
  assign status_o    = st_q;

  // A result is only shown once the sequencer is back at rest.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while sequencer busy");

  // Banks swap exactly when a rectangle is placed.
  a_bank_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bank_q != $past(bank_q)) |-> (done_o && status_o == ST_PLACED))
    else $error("bank swapped without a placement");

  // The live skyline never exceeds the store.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count beyond store");

  // A batch start seeds a single segment and clears the failure flag.
  a_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |=> (cnt_q == CNT_W'(1) && !failed_q))
    else $error("batch start did not reset the skyline");

  // An accepted transaction makes the block busy on the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_o && !done_o))
    else $error("accepted transaction not started");

endmodule
`default_nettype wire
